// ----- src/owfcrc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the 1-Wire frame CRC checker: frame geometry, CRC-8 constants
// and the byte-wide CRC-8 update function. Depends on nothing.
package owfcrc_pkg;

  localparam logic [7:0]  CRC_REFL_POLY = 8'h8C;
  localparam logic [3:0]  SCRATCH_CRC_POS = 4'd8;
  localparam logic [3:0]  ROM_CRC_POS = 4'd7;
  localparam logic [13:0] FRAC_STEP = 14'd625;
  localparam logic [11:0] WHOLE_MAX = 12'd2048;
  localparam logic [13:0] FRAC_MAX = 14'd9375;

  typedef enum logic {
    MODE_SCRATCHPAD = 1'b0,
    MODE_ROM        = 1'b1
  } frame_mode_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] crc;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (crc[0] ^ b[k]) begin
        crc = (crc >> 1) ^ CRC_REFL_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ----- src/onewire_frame_crc_checker.sv -----
`timescale 1ns / 1ps
// Top level of the 1-Wire frame CRC checker: input register, frame state and
// result register. Depends on owfcrc_pkg.

// The block takes one byte word in every cycle while in_stall is low. The frame's CRC byte
// passes the input register and then the result register, which delivers the result word;
// between the two lies a combinational byte-wide CRC-8 update and check. A frame
// starts on a word with first_byte set; in scratchpad mode the ninth word is the
// CRC byte, in ROM mode the eighth. Words that arrive while no frame is open are
// dropped without a result. The input side stalls only when the CRC byte of a
// frame waits while an earlier result is still held by a stalled output.
module onewire_frame_crc_checker
  import owfcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        crc_ok,
  output logic        is_negative,
  output logic [11:0] whole_degrees,
  output logic [13:0] frac_ten_thousandths,
  output logic [7:0]  family_code,
  output logic [63:0] rom_code
);

  frame_mode_t frame_mode;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;

  logic [7:0]  crc_running;
  logic [3:0]  byte_index;
  logic [63:0] frame_bytes;
  logic        frame_open;

  logic        eff_open;
  logic [7:0]  eff_crc;
  logic [3:0]  eff_idx;
  logic [63:0] eff_bytes;
  logic [3:0]  last_pos;
  logic        is_data;
  logic        produce;
  logic        s1_go;
  logic        in_accept;

  logic [7:0]  crc_next;
  logic [63:0] frame_bytes_next;
  logic [63:0] rom_full;
  logic [15:0] raw;
  logic [15:0] mag;

  always_comb begin
    eff_open  = s1_first | frame_open;
    eff_crc   = s1_first ? 8'd0 : crc_running;
    eff_idx   = s1_first ? 4'd0 : byte_index;
    eff_bytes = s1_first ? 64'd0 : frame_bytes;
    last_pos  = (frame_mode == MODE_ROM) ? ROM_CRC_POS : SCRATCH_CRC_POS;
    is_data   = eff_idx < last_pos;
    produce   = s1_valid & eff_open & ~is_data;
    s1_go     = s1_valid & (~produce | ~out_valid | ~out_stall);
    in_stall  = s1_valid & ~s1_go;
    in_accept = in_valid & ~in_stall;

    crc_next = crc8_byte(eff_crc, s1_byte);
    frame_bytes_next = eff_bytes;
    for (int i = 0; i < 8; i++) begin
      if (eff_idx[2:0] == 3'(i)) begin
        frame_bytes_next[8*i +: 8] = s1_byte;
      end
    end
    rom_full = eff_bytes;
    if (eff_idx == ROM_CRC_POS) begin
      rom_full[63:56] = s1_byte;
    end

    raw = eff_bytes[15:0];
    mag = raw[15] ? (16'd0 - raw) : raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode  <= MODE_SCRATCHPAD;
      s1_valid    <= 1'b0;
      crc_running <= 8'd0;
      byte_index  <= 4'd0;
      frame_bytes <= 64'd0;
      frame_open  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_mode <= frame_mode_t'(cfg_wdata);
      end

      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go && eff_open) begin
        if (is_data) begin
          crc_running <= crc_next;
          frame_bytes <= frame_bytes_next;
          byte_index  <= eff_idx + 4'd1;
          frame_open  <= 1'b1;
        end else begin
          byte_index <= 4'd0;
          frame_open <= 1'b0;
        end
      end

      if (s1_go && produce) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
    end
    if (s1_go && produce) begin
      crc_ok <= (eff_crc == s1_byte);
      if (frame_mode == MODE_ROM) begin
        is_negative          <= 1'b0;
        whole_degrees        <= 12'd0;
        frac_ten_thousandths <= 14'd0;
        family_code          <= rom_full[7:0];
        rom_code             <= rom_full;
      end else begin
        is_negative          <= raw[15];
        whole_degrees        <= mag[15:4];
        frac_ten_thousandths <= 14'(mag[3:0]) * FRAC_STEP;
        family_code          <= 8'd0;
        rom_code             <= 64'd0;
      end
    end
  end

endmodule

// ----- src/owfcrc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the 1-Wire frame CRC checker and its bind statement.
// Depends on owfcrc_pkg and onewire_frame_crc_checker.
module owfcrc_checker
  import owfcrc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        crc_ok,
  input logic        is_negative,
  input logic [11:0] whole_degrees,
  input logic [13:0] frac_ten_thousandths,
  input logic [7:0]  family_code,
  input logic [63:0] rom_code
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rom_code) && $stable(crc_ok)
      && $stable(whole_degrees) && $stable(frac_ten_thousandths))
    else $error("stalled result word changed");

  a_family: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> family_code == rom_code[7:0])
    else $error("family code differs from the first ROM byte");

  a_rom_no_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && rom_code != 64'd0 |->
      !is_negative && whole_degrees == 12'd0 && frac_ten_thousandths == 14'd0)
    else $error("temperature fields set on a ROM word");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> whole_degrees <= WHOLE_MAX && frac_ten_thousandths <= FRAC_MAX)
    else $error("temperature field out of range");

  a_most_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid && whole_degrees == WHOLE_MAX |-> is_negative && frac_ten_thousandths == 14'd0)
    else $error("full-scale magnitude without the most negative reading");

endmodule

bind onewire_frame_crc_checker owfcrc_checker u_owfcrc_checker (.*);

// ----- bench/frame_result_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 1-Wire frame CRC checker: watches the byte and result channels,
// predicts each frame result and compares it field by field. Depends on owfcrc_pkg.
module frame_result_checker
  import owfcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        crc_ok,
  input  logic        is_negative,
  input  logic [11:0] whole_degrees,
  input  logic [13:0] frac_ten_thousandths,
  input  logic [7:0]  family_code,
  input  logic [63:0] rom_code,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        crc_ok;
    logic        is_negative;
    logic [11:0] whole_degrees;
    logic [13:0] frac;
    logic [7:0]  family_code;
    logic [63:0] rom_code;
  } frame_result_t;

  frame_result_t predicted_frames [$];
  frame_mode_t   mode;
  logic [7:0]    crc_acc;
  logic [3:0]    pos;
  logic [63:0]   frame_buf;
  logic          in_frame;

  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_REFL_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic f);
    logic [3:0]    last_pos;
    logic [15:0]   raw;
    logic [16:0]   mag;
    frame_result_t r;
    last_pos = (mode == MODE_ROM) ? ROM_CRC_POS : SCRATCH_CRC_POS;
    if (f) begin
      crc_acc = 8'h00;
      pos = 4'd0;
      frame_buf = 64'h0;
      in_frame = 1'b1;
    end
    if (in_frame) begin
      if (pos < last_pos) begin
        crc_acc = crc8_next(crc_acc, b);
        if (pos < 4'd8) begin
          frame_buf[{pos[2:0], 3'b000} +: 8] = b;
        end
        pos = pos + 4'd1;
      end else begin
        r = '0;
        r.crc_ok = (crc_acc == b);
        if (mode == MODE_ROM) begin
          if (pos < 4'd8) begin
            frame_buf[{pos[2:0], 3'b000} +: 8] = b;
          end
          r.family_code = frame_buf[7:0];
          r.rom_code = frame_buf;
        end else begin
          raw = frame_buf[15:0];
          mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
          r.is_negative = raw[15];
          r.whole_degrees = mag[15:4];
          r.frac = mag[3:0] * FRAC_STEP;
        end
        predicted_frames.push_back(r);
        in_frame = 1'b0;
        pos = 4'd0;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    frame_result_t r;
    if (predicted_frames.size() == 0) begin
      fail_count++;
      $display("%0t: result word expected none, actual crc_ok=%0h rom_code=%0h",
               $time, crc_ok, rom_code);
    end else begin
      r = predicted_frames.pop_front();
      report_field("crc_ok", 64'(r.crc_ok), 64'(crc_ok));
      report_field("is_negative", 64'(r.is_negative), 64'(is_negative));
      report_field("whole_degrees", 64'(r.whole_degrees), 64'(whole_degrees));
      report_field("frac_ten_thousandths", 64'(r.frac), 64'(frac_ten_thousandths));
      report_field("family_code", 64'(r.family_code), 64'(family_code));
      report_field("rom_code", r.rom_code, rom_code);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      predicted_frames.delete();
      mode = MODE_SCRATCHPAD;
      crc_acc = 8'h00;
      pos = 4'd0;
      frame_buf = 64'h0;
      in_frame = 1'b0;
    end else begin
      if (cfg_we) begin
        mode = cfg_wdata ? MODE_ROM : MODE_SCRATCHPAD;
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (in_valid && !in_stall) begin
        absorb_byte(data_byte, first_byte);
      end
    end
    pending <= predicted_frames.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the bench for the 1-Wire frame CRC checker: clock, reset, byte frames,
// output stalls and the verdict. Depends on owfcrc_pkg, frame_result_checker and onewire_frame_crc_checker.
module tb_top;
  import owfcrc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        crc_ok;
  logic        is_negative;
  logic [11:0] whole_degrees;
  logic [13:0] frac_ten_thousandths;
  logic [7:0]  family_code;
  logic [63:0] rom_code;

  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          items = 0;
  frame_mode_t cur_mode = MODE_SCRATCHPAD;

  onewire_frame_crc_checker dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .data_byte            (data_byte),
    .first_byte           (first_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .crc_ok               (crc_ok),
    .is_negative          (is_negative),
    .whole_degrees        (whole_degrees),
    .frac_ten_thousandths (frac_ten_thousandths),
    .family_code          (family_code),
    .rom_code             (rom_code)
  );

  frame_result_checker u_checker (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .data_byte            (data_byte),
    .first_byte           (first_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .crc_ok               (crc_ok),
    .is_negative          (is_negative),
    .whole_degrees        (whole_degrees),
    .frac_ten_thousandths (frac_ten_thousandths),
    .family_code          (family_code),
    .rom_code             (rom_code),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // A long hold-off, once requested, overrides the random stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] != b[k]) begin
        c = {1'b0, c[7:1]} ^ CRC_REFL_POLY;
      end else begin
        c = {1'b0, c[7:1]};
      end
    end
    return c;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle(input int limit);
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input frame_mode_t m);
    settle(50000);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  // The CRC byte sits at position len-1; only the first cut words are sent.
  task automatic send_block(input logic [7:0] fb [0:8], input int len, input int cut,
                            input bit good);
    logic [7:0] blk [0:8];
    logic [7:0] crc;
    blk = fb;
    crc = 8'h00;
    for (int k = 0; k < len - 1; k++) begin
      crc = crc_step(crc, blk[k]);
    end
    blk[len - 1] = good ? crc : (crc ^ (8'h01 << $urandom_range(7)));
    for (int k = 0; k < cut; k++) begin
      send_word(blk[k], k == 0);
    end
    items += cut;
  endtask

  task automatic send_frame();
    logic [7:0] fb [0:8];
    int len;
    int kind;
    int cut;
    len = (cur_mode == MODE_ROM) ? 8 : 9;
    foreach (fb[k]) fb[k] = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: {fb[1], fb[0]} = 16'h8000;
        1: {fb[1], fb[0]} = 16'h7FFF;
        2: {fb[1], fb[0]} = 16'h0000;
        default: {fb[1], fb[0]} = 16'hFFFF;
      endcase
    end
    kind = $urandom_range(99);
    cut = (kind >= 12 && kind < 24) ? $urandom_range(1, len - 1) : len;
    send_block(fb, len, cut, kind >= 12);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    logic [7:0] fb [0:8];
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_SCRATCHPAD);
    send_word(8'hA5, 1'b0);
    send_word(8'h3C, 1'b1);
    foreach (fb[k]) fb[k] = 8'h00;
    fb[1] = 8'h80;
    send_block(fb, 9, 9, 1'b1);
    send_word(8'h5A, 1'b0);

    write_mode(MODE_ROM);
    foreach (fb[k]) fb[k] = 8'hFF;
    send_block(fb, 8, 8, 1'b1);
    send_block(fb, 9, 3, 1'b1);
    write_mode(MODE_SCRATCHPAD);
    for (int k = 0; k < 6; k++) begin
      send_word(8'(16 + k), 1'b0);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_mode((((ph ^ (ph >> 2)) & 1) != 0) ? MODE_ROM : MODE_SCRATCHPAD);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      if (ph == 0) begin
        hold_req++;
      end
      target = items + 131;
      while (items < target) send_frame();
      if ($urandom_range(1) == 1) begin
        foreach (fb[k]) fb[k] = 8'($urandom_range(255));
        send_block(fb, 9, $urandom_range(1, 8), 1'b1);
      end
    end

    stall_pct = 0;
    settle(50000);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
